### rtl/seuc_pkg.sv
package seuc_pkg;

   // input action codes
   localparam logic [1:0] ACT_START = 2'd0;
   localparam logic [1:0] ACT_DATA  = 2'd1;
   localparam logic [1:0] ACT_END   = 2'd2;

   // characters and byte classes
   localparam logic [7:0] CHR_QUOTE     = 8'h22;
   localparam logic [7:0] CHR_BACKSLASH = 8'h5c;
   localparam logic [7:0] CHR_DEL       = 8'h7f;
   localparam logic [7:0] CTRL_LIMIT    = 8'h20;
   localparam logic [7:0] SURR_LEAD     = 8'hed;
   localparam logic [7:0] SURR_MASK     = 8'ha0;

   // job queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int JOB_OPS     = 4;

   // one emission unit: a byte and how it is written out
   typedef enum logic [2:0] {
      OP_RAW,   // the byte itself
      OP_BSL,   // backslash, then the byte
      OP_OCT,   // backslash and three octal digits
      OP_UNI,   // \u00 and two hex digits
      OP_ERR    // one error word
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic [7:0]  value;
   } op_type;

   // all emissions caused by one input word
   typedef struct packed {
      op_type [JOB_OPS-1:0] ops;
      logic   [2:0]         count;
   } job_type;

   // classification result of a single byte
   typedef struct packed {
      logic   push;
      op_type op;
      logic   lead;
      logic   abort;
   } class_type;

   // length of the UTF-8 sequence a lead byte opens, 0 when not a lead
   function automatic logic [2:0] seq_len(logic [7:0] c);
      logic [2:0] n;
      priority if ((c & 8'he0) == 8'hc0) n = 3'd2;
      else if ((c & 8'hf0) == 8'he0) n = 3'd3;
      else if ((c & 8'hf8) == 8'hf0) n = 3'd4;
      else n = 3'd0;
      return n;
   endfunction

   // a high byte that fits no sequence
   function automatic class_type stray_op(logic [7:0] c, logic json, logic ab);
      class_type r;
      r.push     = !ab;
      r.op.kind  = json ? OP_ERR : OP_OCT;
      r.op.value = c;
      r.lead     = 1'b0;
      r.abort    = json && !ab;
      return r;
   endfunction

   // a byte met with nothing held
   function automatic class_type fresh_op(logic [7:0] c, logic json, logic ab);
      class_type r;
      r.push     = 1'b0;
      r.op.kind  = OP_RAW;
      r.op.value = c;
      r.lead     = 1'b0;
      r.abort    = 1'b0;
      if (!ab) begin
         priority if (c < CTRL_LIMIT || c == CHR_DEL) begin
            r.push    = 1'b1;
            r.op.kind = json ? OP_UNI : OP_OCT;
         end else if (c == CHR_QUOTE || c == CHR_BACKSLASH) begin
            r.push    = 1'b1;
            r.op.kind = OP_BSL;
         end else if (seq_len(c) != 3'd0) begin
            r.lead = 1'b1;
         end else if (c[7]) begin
            r = stray_op(c, json, ab);
         end else begin
            r.push = 1'b1;
         end
      end
      return r;
   endfunction

endpackage

### rtl/seuc_req_if.sv
interface seuc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [7:0] data_byte;

   modport source (output valid, action, data_byte, input ready);
   modport sink   (input valid, action, data_byte, output ready);
endinterface

### rtl/seuc_rsp_if.sv
interface seuc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       last_of_run;
   logic       error;

   modport source (output valid, out_char, last_of_run, error, input ready);
   modport sink   (input valid, out_char, last_of_run, error, output ready);
endinterface

### rtl/seuc_front.sv
module seuc_front (
   input  logic              clock,
   input  logic              reset,
   seuc_req_if.sink          req_chan,
   input  logic              json_mode,
   input  logic              queue_full,
   output logic              push,
   output seuc_pkg::job_type push_job
);

   logic [7:0] pend_ff [3];
   logic [7:0] pend_in [3];
   logic [1:0] cnt_ff, cnt_in;
   logic       aborted_ff, aborted_in;

   logic [2:0]          n;
   logic [2:0]          need;
   seuc_pkg::class_type cl;
   logic                accept;

   assign req_chan.ready = !queue_full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign need           = seuc_pkg::seq_len(pend_ff[0]);

   // classify the word and build its job
   always_comb begin
      logic [7:0] b;
      b          = req_chan.data_byte;
      pend_in    = pend_ff;
      cnt_in     = cnt_ff;
      aborted_in = aborted_ff;
      n          = 3'd0;
      cl         = seuc_pkg::fresh_op(b, json_mode, 1'b1);
      for (int i = 0; i < seuc_pkg::JOB_OPS; i++) begin
         push_job.ops[i].kind  = seuc_pkg::OP_RAW;
         push_job.ops[i].value = 8'h00;
      end

      unique case (req_chan.action)
         seuc_pkg::ACT_START: begin
            cnt_in     = 2'd0;
            aborted_in = 1'b0;
            push_job.ops[0].value = seuc_pkg::CHR_QUOTE;
            n = 3'd1;
         end
         seuc_pkg::ACT_DATA: begin
            if (!aborted_ff) begin
               if (cnt_ff == 2'd0) begin
                  cl = seuc_pkg::fresh_op(b, json_mode, aborted_in);
               end else if (pend_ff[0] == seuc_pkg::SURR_LEAD && cnt_ff == 2'd1 &&
                            (b & seuc_pkg::SURR_MASK) == seuc_pkg::SURR_MASK) begin
                  // surrogate range after 0xED: reject the lead
                  cnt_in = 2'd0;
                  cl = seuc_pkg::stray_op(pend_ff[0], json_mode, aborted_in);
                  if (cl.push) begin
                     push_job.ops[n[1:0]] = cl.op;
                     n = n + 3'd1;
                  end
                  aborted_in = aborted_in | cl.abort;
                  cl = seuc_pkg::fresh_op(b, json_mode, aborted_in);
               end else if (b[7:6] == 2'b10) begin
                  if ({1'b0, cnt_ff} + 3'd1 >= need) begin
                     // sequence complete: pass it through
                     for (int i = 0; i < 3; i++) begin
                        if (2'(i) < cnt_ff) begin
                           push_job.ops[n[1:0]].value = pend_ff[i];
                           n = n + 3'd1;
                        end
                     end
                     push_job.ops[n[1:0]].value = b;
                     n = n + 3'd1;
                     cnt_in = 2'd0;
                  end else begin
                     pend_in[cnt_ff] = b;
                     cnt_in = cnt_ff + 2'd1;
                  end
               end else begin
                  // broken sequence: flush held bytes
                  cnt_in = 2'd0;
                  for (int i = 0; i < 3; i++) begin
                     if (2'(i) < cnt_ff) begin
                        cl = seuc_pkg::stray_op(pend_ff[i], json_mode, aborted_in);
                        if (cl.push) begin
                           push_job.ops[n[1:0]] = cl.op;
                           n = n + 3'd1;
                        end
                        aborted_in = aborted_in | cl.abort;
                     end
                  end
                  cl = seuc_pkg::fresh_op(b, json_mode, aborted_in);
               end
               // the byte handled afresh
               if (cl.push) begin
                  push_job.ops[n[1:0]] = cl.op;
                  n = n + 3'd1;
               end
               aborted_in = aborted_in | cl.abort;
               if (cl.lead) begin
                  pend_in[0] = b;
                  cnt_in     = 2'd1;
               end
            end
         end
         seuc_pkg::ACT_END: begin
            if (!aborted_ff) begin
               cnt_in = 2'd0;
               for (int i = 0; i < 3; i++) begin
                  if (2'(i) < cnt_ff) begin
                     cl = seuc_pkg::stray_op(pend_ff[i], json_mode, aborted_in);
                     if (cl.push) begin
                        push_job.ops[n[1:0]] = cl.op;
                        n = n + 3'd1;
                     end
                     aborted_in = aborted_in | cl.abort;
                  end
               end
               if (!aborted_in) begin
                  push_job.ops[n[1:0]].value = seuc_pkg::CHR_QUOTE;
                  n = n + 3'd1;
               end
            end
         end
         default: begin
         end
      endcase
      push_job.count = n;
   end

   assign push = accept && (n != 3'd0);

   // held bytes carry no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= 2'd0;
         aborted_ff <= 1'b0;
      end else if (accept) begin
         cnt_ff     <= cnt_in;
         aborted_ff <= aborted_in;
      end
   end

endmodule

### rtl/seuc_queue.sv
module seuc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  seuc_pkg::job_type push_job,
   input  logic              pop,
   output seuc_pkg::job_type head_job,
   output logic              empty,
   output logic              full
);

   seuc_pkg::job_type                 entry_ff [seuc_pkg::QUEUE_DEPTH];
   logic [seuc_pkg::QUEUE_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [seuc_pkg::QUEUE_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [seuc_pkg::QUEUE_AW:0]       count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == (seuc_pkg::QUEUE_AW+1)'(seuc_pkg::QUEUE_DEPTH));
   assign head_job = entry_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/seuc_back.sv
module seuc_back (
   input  logic              clock,
   input  logic              reset,
   input  seuc_pkg::job_type head_job,
   input  logic              empty,
   output logic              pop,
   seuc_rsp_if.source        rsp_chan
);

   logic [1:0] op_idx_ff, op_idx_in;
   logic [2:0] step_ff, step_in;
   logic       valid_ff, valid_in;
   logic [7:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       err_ff, err_in;

   seuc_pkg::op_type cur;
   logic [2:0]       len;
   logic             last_step, last_op, advance;

   // number of characters an op writes
   function automatic logic [2:0] op_len(seuc_pkg::op_kind_type k);
      logic [2:0] l;
      unique case (k)
         seuc_pkg::OP_BSL: l = 3'd2;
         seuc_pkg::OP_OCT: l = 3'd4;
         seuc_pkg::OP_UNI: l = 3'd6;
         default:          l = 3'd1;
      endcase
      return l;
   endfunction

   function automatic logic [7:0] hex_char(logic [3:0] v);
      return (v < 4'd10) ? 8'h30 + {4'h0, v} : 8'h57 + {4'h0, v};
   endfunction

   // character at one step of an op
   function automatic logic [7:0] op_char(seuc_pkg::op_type o, logic [2:0] s);
      logic [7:0] c;
      c = o.value;
      unique case (o.kind)
         seuc_pkg::OP_BSL: c = (s == 3'd0) ? seuc_pkg::CHR_BACKSLASH : o.value;
         seuc_pkg::OP_OCT: begin
            unique case (s)
               3'd0:    c = seuc_pkg::CHR_BACKSLASH;
               3'd1:    c = 8'h30 + {6'h0, o.value[7:6]};
               3'd2:    c = 8'h30 + {5'h0, o.value[5:3]};
               default: c = 8'h30 + {5'h0, o.value[2:0]};
            endcase
         end
         seuc_pkg::OP_UNI: begin
            unique case (s)
               3'd0:    c = seuc_pkg::CHR_BACKSLASH;
               3'd1:    c = 8'h75;
               3'd2:    c = 8'h30;
               3'd3:    c = 8'h30;
               3'd4:    c = hex_char(o.value[7:4]);
               default: c = hex_char(o.value[3:0]);
            endcase
         end
         seuc_pkg::OP_ERR: c = 8'h00;
         default:          c = o.value;
      endcase
      return c;
   endfunction

   assign cur       = head_job.ops[op_idx_ff];
   assign len       = op_len(cur.kind);
   assign last_step = (step_ff == len - 3'd1);
   assign last_op   = ({1'b0, op_idx_ff} + 3'd1 == head_job.count);
   assign advance   = !empty && (!valid_ff || rsp_chan.ready);
   assign pop       = advance && last_step && last_op;

   // serialize one character per cycle into the output register while a job waits and rsp_chan does not stall
   always_comb begin
      op_idx_in = op_idx_ff;
      step_in   = step_ff;
      char_in   = char_ff;
      last_in   = last_ff;
      err_in    = err_ff;
      valid_in  = valid_ff && !rsp_chan.ready;
      if (advance) begin
         valid_in = 1'b1;
         char_in  = op_char(cur, step_ff);
         err_in   = (cur.kind == seuc_pkg::OP_ERR);
         last_in  = last_step && last_op;
         if (last_step) begin
            step_in   = 3'd0;
            op_idx_in = last_op ? 2'd0 : op_idx_ff + 2'd1;
         end else begin
            step_in = step_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
      err_ff  <= err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_idx_ff <= 2'd0;
         step_ff   <= 3'd0;
         valid_ff  <= 1'b0;
      end else begin
         op_idx_ff <= op_idx_in;
         step_ff   <= step_in;
         valid_ff  <= valid_in;
      end
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.out_char    = char_ff;
   assign rsp_chan.last_of_run = last_ff;
   assign rsp_chan.error       = err_ff;

endmodule

### rtl/string_escape_utf8_check_unit.sv
// String escaper with UTF-8 pass-through.
// req_chan takes words: start, data byte or end. rsp_chan gives the quoted
// literal one character per word, last_of_run set on the final character
// caused by one request word, error set on the single error word of JSON
// mode. csr_write_enable/csr_write_data set json_mode; write it only idle.
// Flow: a request word is classified in its accept cycle and its job is
// written into the queue; from the queue head the serializer then loads its
// first character into the output register. While rsp_chan is ready the
// serializer gives one character per cycle; a word yields 1 to 16
// characters, and words that only hold a UTF-8 byte yield none at the
// output. With one-character words and rsp_chan ready the unit sustains one
// word per cycle.
// A 4-entry job queue parts classifier and serializer: when rsp_chan stalls
// the output register holds its word, the queue fills, then req_chan.ready
// drops. Reset (synchronous) empties the queue, clears the held-byte count,
// the abort flag and json_mode.
module string_escape_utf8_check_unit (
   input  logic        clock,
   input  logic        reset,
   seuc_req_if.sink    req_chan,
   seuc_rsp_if.source  rsp_chan,
   input  logic        csr_write_enable,
   input  logic        csr_write_data
);

   logic              json_mode_ff, json_mode_in;
   logic              push, pop, empty, full;
   seuc_pkg::job_type push_job, head_job;

   // mode register
   assign json_mode_in = csr_write_enable ? csr_write_data : json_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         json_mode_ff <= 1'b0;
      end else begin
         json_mode_ff <= json_mode_in;
      end
   end

   seuc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .json_mode  (json_mode_ff),
      .queue_full (full),
      .push       (push),
      .push_job   (push_job)
   );

   seuc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .empty    (empty),
      .full     (full)
   );

   seuc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_job (head_job),
      .empty    (empty),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

### tb/sv/string_escape_utf8_check_unit_tb.sv
`timescale 1ns / 100ps

module string_escape_utf8_check_unit_tb;
   import seuc_pkg::*;

   // action code the block ignores
   localparam logic [1:0] ACT_NONE = 2'd3;

   // characters used by the escapes
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_A    = 8'h61;
   localparam logic [7:0] CH_U    = 8'h75;

   localparam int MAX_CHARS   = 16;
   localparam int HOLD_CYCLES = 60;

   // one character of the escaped literal
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       err;
   } lit_char_t;

   // one row of the directed stimulus
   typedef struct {
      bit         json;
      logic [1:0] act;
      logic [7:0] b;
      string      want;
      bit         want_err;
   } dir_row_t;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic csr_write_data;

   seuc_req_if req_if ();
   seuc_rsp_if rsp_if ();

   string_escape_utf8_check_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // escaper state as the testbench sees it
   logic       json_q    = 1'b0;
   logic [7:0] held_b [3];
   int         held_n    = 0;
   bit         aborted_q = 1'b0;

   lit_char_t  run_buf [$];
   lit_char_t  literal_q [$];
   lit_char_t  got_w;

   // typed expectation that travels with the word being offered
   bit         hand_on  = 1'b0;
   string      hand_want;
   bit         hand_err = 1'b0;

   // sender and receiver pacing
   bit         tx_idle    = 1'b0;
   int         burst_left = 0;
   int         rx_mode    = 0;
   logic [7:0] rx_pat     = 8'b1011_0010;
   bit         hold_req   = 1'b0;
   bit         hold_done  = 1'b0;

   int         mismatches = 0;
   int         words_in   = 0;
   int         chars_seen = 0;
   int         err_seen   = 0;
   int         directed_n = 0;

   dir_row_t   dir_rows [$];

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   task automatic flag_mismatch(string msg);
      mismatches++;
      $display("mismatch at %0t: %s", $time, msg);
   endtask

   // ---------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------
   function automatic int utf8_lead_len(logic [7:0] c);
      if (c[7:5] == 3'b110) return 2;
      if (c[7:4] == 4'b1110) return 3;
      if (c[7:3] == 5'b11110) return 4;
      return 0;
   endfunction

   function automatic logic [7:0] hex_char(logic [3:0] v);
      return (v < 4'd10) ? CH_ZERO + 8'(v) : CH_A + 8'(v) - 8'd10;
   endfunction

   task automatic put_char(logic [7:0] c, logic e);
      if (run_buf.size() < MAX_CHARS)
         run_buf.push_back('{ch: c, last: 1'b0, err: e});
   endtask

   task automatic put_octal(logic [7:0] c);
      put_char(CHR_BACKSLASH, 1'b0);
      put_char(CH_ZERO + 8'(c[7:6]), 1'b0);
      put_char(CH_ZERO + 8'(c[5:3]), 1'b0);
      put_char(CH_ZERO + 8'(c[2:0]), 1'b0);
   endtask

   // high byte outside any sequence: octal, or the one error word in JSON
   task automatic put_stray(logic [7:0] c);
      if (aborted_q) return;
      if (json_q) begin
         put_char(8'h00, 1'b1);
         aborted_q = 1'b1;
      end else begin
         put_octal(c);
      end
   endtask

   // byte met with nothing held
   task automatic escape_fresh(logic [7:0] c);
      if (aborted_q) return;
      if (c < CTRL_LIMIT || c == CHR_DEL) begin
         if (json_q) begin
            put_char(CHR_BACKSLASH, 1'b0);
            put_char(CH_U, 1'b0);
            put_char(CH_ZERO, 1'b0);
            put_char(CH_ZERO, 1'b0);
            put_char(hex_char(c[7:4]), 1'b0);
            put_char(hex_char(c[3:0]), 1'b0);
         end else begin
            put_octal(c);
         end
      end else if (c == CHR_QUOTE || c == CHR_BACKSLASH) begin
         put_char(CHR_BACKSLASH, 1'b0);
         put_char(c, 1'b0);
      end else if (utf8_lead_len(c) != 0) begin
         held_b[0] = c;
         held_n    = 1;
      end else if (c[7]) begin
         put_stray(c);
      end else begin
         put_char(c, 1'b0);
      end
   endtask

   task automatic flush_held();
      int n;
      n      = held_n;
      held_n = 0;
      for (int i = 0; i < n && i < 3; i++)
         put_stray(held_b[i]);
   endtask

   task automatic take_byte(logic [7:0] b);
      int need;
      if (held_n == 0) begin
         escape_fresh(b);
         return;
      end
      need = utf8_lead_len(held_b[0]);
      if (held_b[0] == SURR_LEAD && held_n == 1 && (b & SURR_MASK) == SURR_MASK) begin
         // surrogate range: lead goes out alone, the byte starts over
         held_n = 0;
         put_stray(held_b[0]);
         escape_fresh(b);
      end else if (b[7:6] == 2'b10) begin
         if (held_n + 1 >= need) begin
            for (int i = 0; i < held_n && i < 3; i++)
               put_char(held_b[i], 1'b0);
            put_char(b, 1'b0);
            held_n = 0;
         end else if (held_n < 3) begin
            held_b[held_n] = b;
            held_n++;
         end
      end else begin
         flush_held();
         escape_fresh(b);
      end
   endtask

   task automatic close_run();
      if (run_buf.size() > 0)
         run_buf[run_buf.size() - 1].last = 1'b1;
   endtask

   // all characters caused by one request word
   task automatic escape_word(logic [1:0] act, logic [7:0] b);
      run_buf.delete();
      case (act)
         ACT_START: begin
            held_n    = 0;
            aborted_q = 1'b0;
            put_char(CHR_QUOTE, 1'b0);
         end
         ACT_DATA: begin
            if (!aborted_q) take_byte(b);
         end
         ACT_END: begin
            if (!aborted_q) begin
               flush_held();
               if (!aborted_q) put_char(CHR_QUOTE, 1'b0);
            end
         end
         default: ;
      endcase
      close_run();
   endtask

   // ---------------------------------------------------------------
   // monitor: results first, then the accepted request, then csr
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            chars_seen++;
            if (rsp_if.error) err_seen++;
            if (literal_q.size() == 0) begin
               flag_mismatch($sformatf("word with nothing expected: char %h last %b err %b",
                  rsp_if.out_char, rsp_if.last_of_run, rsp_if.error));
            end else begin
               got_w = literal_q.pop_front();
               if (rsp_if.out_char !== got_w.ch)
                  flag_mismatch($sformatf("out_char %h, want %h", rsp_if.out_char, got_w.ch));
               if (rsp_if.last_of_run !== got_w.last)
                  flag_mismatch($sformatf("last_of_run %b, want %b",
                     rsp_if.last_of_run, got_w.last));
               if (rsp_if.error !== got_w.err)
                  flag_mismatch($sformatf("error %b, want %b", rsp_if.error, got_w.err));
            end
         end
         if (req_if.valid && req_if.ready) begin
            if (req_if.action != ACT_NONE) words_in++;
            escape_word(req_if.action, req_if.data_byte);
            if (hand_on) begin
               run_buf.delete();
               if (hand_err)
                  run_buf.push_back('{ch: 8'h00, last: 1'b0, err: 1'b1});
               else
                  for (int i = 0; i < hand_want.len(); i++)
                     run_buf.push_back('{ch: hand_want[i], last: 1'b0, err: 1'b0});
               close_run();
            end
            foreach (run_buf[i]) literal_q.push_back(run_buf[i]);
         end
         if (csr_write_enable) json_q = csr_write_data;
      end
   end

   // ---------------------------------------------------------------
   // receiver: long hold on request, otherwise its current pattern
   // ---------------------------------------------------------------
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req && !hold_done) begin
            rsp_if.ready = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            case (rx_mode)
               0: rsp_if.ready = 1'b1;
               1: rsp_if.ready = ($urandom_range(0, 3) != 0);
               2: rsp_if.ready = ($urandom_range(0, 2) == 0);
               default: begin
                  rsp_if.ready = rx_pat[0];
                  rx_pat = {rx_pat[0], rx_pat[7:1]};
               end
            endcase
         end
      end
   end

   // ---------------------------------------------------------------
   // sender
   // ---------------------------------------------------------------
   // offer one word from a falling edge, return at the falling edge after it is taken
   task automatic send_word(logic [1:0] act, logic [7:0] b);
      if (tx_idle && burst_left == 0) begin
         req_if.valid = 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
         burst_left = $urandom_range(1, 10);
      end
      req_if.valid     = 1'b1;
      req_if.action    = act;
      req_if.data_byte = b;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
      if (burst_left > 0) burst_left--;
   endtask

   // stop offering and let every expected word come out
   task automatic wait_idle();
      req_if.valid = 1'b0;
      while (literal_q.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic set_mode(bit json);
      wait_idle();
      csr_write_enable = 1'b1;
      csr_write_data   = json;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   function automatic dir_row_t row(bit json, logic [1:0] act, logic [7:0] b,
                                    string want, bit want_err);
      dir_row_t r;
      r.json     = json;
      r.act      = act;
      r.b        = b;
      r.want     = want;
      r.want_err = want_err;
      return r;
   endfunction

   // random string, mostly well formed, with UTF-8 runs whole or broken
   task automatic send_string();
      int         len;
      int         n;
      int         conts;
      logic [7:0] lead;
      tx_idle = (hold_req && !hold_done) ? 1'b0 : ($urandom_range(0, 2) != 0);
      rx_mode = $urandom_range(0, 3);
      if ($urandom_range(0, 9) != 0) send_word(ACT_START, 8'($urandom_range(0, 255)));
      len = $urandom_range(0, 8);
      for (int k = 0; k < len; k++) begin
         case ($urandom_range(0, 15))
            0, 1, 2, 3, 4, 5: send_word(ACT_DATA, 8'($urandom_range(8'h20, 8'h7e)));
            6: send_word(ACT_DATA, ($urandom_range(0, 4) == 0) ? CHR_DEL
                                   : 8'($urandom_range(0, 8'h1f)));
            7: send_word(ACT_DATA, $urandom_range(0, 1) ? CHR_QUOTE : CHR_BACKSLASH);
            8, 9, 10, 11: begin
               n = $urandom_range(2, 4);
               case (n)
                  2: lead = 8'hc0 | 8'($urandom_range(0, 8'h1f));
                  3: lead = 8'he0 | 8'($urandom_range(0, 8'h0f));
                  default: lead = 8'hf0 | 8'($urandom_range(0, 8'h07));
               endcase
               conts = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n - 2) : n - 1;
               send_word(ACT_DATA, lead);
               repeat (conts) send_word(ACT_DATA, 8'h80 | 8'($urandom_range(0, 8'h3f)));
            end
            12: begin
               // lead that opens the surrogate range, rejected or not
               send_word(ACT_DATA, SURR_LEAD);
               if ($urandom_range(0, 1)) begin
                  send_word(ACT_DATA, 8'ha0 | 8'($urandom_range(0, 8'h1f)));
               end else begin
                  send_word(ACT_DATA, 8'h80 | 8'($urandom_range(0, 8'h1f)));
                  send_word(ACT_DATA, 8'h80 | 8'($urandom_range(0, 8'h3f)));
               end
            end
            13: send_word(ACT_DATA, 8'($urandom_range(8'h80, 8'hff)));
            14: send_word(ACT_DATA, 8'($urandom_range(0, 255)));
            default: send_word(ACT_NONE, 8'($urandom_range(0, 255)));
         endcase
      end
      if ($urandom_range(0, 9) != 0) send_word(ACT_END, 8'($urandom_range(0, 255)));
   endtask

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------
   initial begin
      bit json_now;
      int spins;
      req_if.valid     = 1'b0;
      req_if.action    = ACT_START;
      req_if.data_byte = 8'h00;
      csr_write_enable = 1'b0;
      csr_write_data   = 1'b0;
      reset            = 1'b1;

      // octal mode: extremes, escapes, UTF-8 whole, surrogate, broken, end with held
      dir_rows.push_back(row(0, ACT_DATA,  8'h7e, "~", 0));       // no start yet
      dir_rows.push_back(row(0, ACT_START, 8'hff, "\"", 0));
      dir_rows.push_back(row(0, ACT_DATA,  8'h00, "\\000", 0));
      dir_rows.push_back(row(0, ACT_DATA,  8'h7f, "\\177", 0));
      dir_rows.push_back(row(0, ACT_DATA,  8'h22, "\\\"", 0));
      dir_rows.push_back(row(0, ACT_DATA,  8'h5c, "\\\\", 0));
      dir_rows.push_back(row(0, ACT_DATA,  8'hff, "\\377", 0));
      dir_rows.push_back(row(0, ACT_DATA,  8'hc3, "", 0));
      dir_rows.push_back(row(0, ACT_DATA,  8'ha9, "", 0));
      dir_rows.push_back(row(0, ACT_DATA,  8'hed, "", 0));
      dir_rows.push_back(row(0, ACT_DATA,  8'ha0, "", 0));
      dir_rows.push_back(row(0, ACT_DATA,  8'he2, "", 0));
      dir_rows.push_back(row(0, ACT_DATA,  8'h41, "", 0));
      dir_rows.push_back(row(0, ACT_DATA,  8'hf0, "", 0));
      dir_rows.push_back(row(0, ACT_DATA,  8'h9f, "", 0));
      dir_rows.push_back(row(0, ACT_DATA,  8'h98, "", 0));
      dir_rows.push_back(row(0, ACT_END,   8'h00, "", 0));
      dir_rows.push_back(row(0, ACT_NONE,  8'h55, "", 0));
      // JSON mode: unicode escape, error on end with held, error on stray
      dir_rows.push_back(row(1, ACT_START, 8'h00, "\"", 0));
      dir_rows.push_back(row(1, ACT_DATA,  8'h1f, "\\u001f", 0));
      dir_rows.push_back(row(1, ACT_DATA,  8'he9, "", 0));
      dir_rows.push_back(row(1, ACT_END,   8'hff, "", 0));
      dir_rows.push_back(row(1, ACT_START, 8'h00, "\"", 0));
      dir_rows.push_back(row(1, ACT_DATA,  8'h80, "", 1));
      dir_rows.push_back(row(1, ACT_DATA,  8'h78, "", 0));
      dir_rows.push_back(row(1, ACT_END,   8'h00, "", 0));

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part
      set_mode(1'b0);
      json_now = 1'b0;
      rx_mode  = 0;
      foreach (dir_rows[i]) begin
         if (dir_rows[i].json != json_now) begin
            set_mode(dir_rows[i].json);
            json_now = dir_rows[i].json;
         end
         hand_on   = (dir_rows[i].want != "") || dir_rows[i].want_err;
         hand_want = dir_rows[i].want;
         hand_err  = dir_rows[i].want_err;
         send_word(dir_rows[i].act, dir_rows[i].b);
      end
      hand_on = 1'b0;
      wait_idle();
      directed_n = words_in;

      // random part in four phases; phase 1 opens with the long receiver hold
      for (int p = 0; p < 4; p++) begin
         set_mode(p == 1 || p == 2);
         if (p == 1) hold_req = 1'b1;
         while (words_in < directed_n + 38 * (p + 1)) send_string();
      end

      // drain and check nothing is left over
      req_if.valid = 1'b0;
      spins = 0;
      while (literal_q.size() != 0 && spins < 4000) begin
         @(negedge clock);
         spins++;
      end
      repeat (20) @(negedge clock);
      if (literal_q.size() != 0)
         flag_mismatch($sformatf("%0d expected words never came", literal_q.size()));

      $display("covered: %0d request words (%0d directed), %0d characters, %0d error words",
         words_in, directed_n, chars_seen, err_seen);
      $display("covered: octal and JSON escaping, UTF-8 runs whole and broken, "
         , "surrogate leads, %0d-cycle receiver hold", HOLD_CYCLES);
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

### filelist.f
rtl/seuc_pkg.sv
rtl/seuc_req_if.sv
rtl/seuc_rsp_if.sv
rtl/seuc_front.sv
rtl/seuc_queue.sv
rtl/seuc_back.sv
rtl/string_escape_utf8_check_unit.sv
tb/sv/string_escape_utf8_check_unit_tb.sv
